// ----- rtl/core/frame_rate_window_statistics_core_defines.svh -----
// Assertion macros for the frame rate window statistics core.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef FRAME_RATE_WINDOW_STATISTICS_CORE_DEFINES_SVH
`define FRAME_RATE_WINDOW_STATISTICS_CORE_DEFINES_SVH

// same-cycle implication
`define FRWS_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FRWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/frws_pkg.sv -----
// Shared constants and types for the frame rate window statistics core.
// No dependencies; imported by every module of the block.
`default_nettype none

package frws_pkg;

   localparam int HISTORY_DEPTH = 64;
   localparam int RECENT_FRAMES = 10;

   localparam int ENTRY_W     = 16;
   localparam int RATE_W      = 17;
   localparam int CENTI_SCALE = 100000;

   // walk covers the ring and, if longer, the whole recent window
   localparam int WALK_LEN   = (RECENT_FRAMES > HISTORY_DEPTH) ? RECENT_FRAMES : HISTORY_DEPTH;
   localparam int ADDR_W     = $clog2(HISTORY_DEPTH);
   localparam int CNT_W      = $clog2(WALK_LEN);
   localparam int SUM_W      = ENTRY_W + $clog2(WALK_LEN);
   localparam int NUM_W      = $clog2(CENTI_SCALE * WALK_LEN + 1);
   localparam int DIV_CNT_W  = $clog2(NUM_W);

   localparam logic [NUM_W-1:0] DIVIDEND_RECENT = NUM_W'(CENTI_SCALE * RECENT_FRAMES);
   localparam logic [NUM_W-1:0] DIVIDEND_AVG    = NUM_W'(CENTI_SCALE * HISTORY_DEPTH);
   localparam logic [NUM_W-1:0] DIVIDEND_SINGLE = NUM_W'(CENTI_SCALE);

   typedef enum logic [1:0] {
      RES_RECENT = 2'd0,
      RES_MIN    = 2'd1,
      RES_AVG    = 2'd2,
      RES_MAX    = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } ring_cmd_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  dividend;
      logic [SUM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/frame_rate_window_statistics_core.sv -----
// Frame rate window statistics core: ring walk sequencer and result register.
// Depends on frws_pkg, frws_ring and frws_divider.
//
//   port group   dir  fields
//   req_*        in   interval_ms[15:0]
//   rsp_*        out  fps_recent/min/avg/max_centi[16:0]
//
// Each request walks the ring, one ring read per cycle, then runs four serial
// divides of NUM_W steps each on the shared divider. req_stall stays high
// from accept until the result is loaded into the output register; a stalled
// result does not block the next request. Reset clears all entry valid bits
// together; there is no clearing pass.
`default_nettype none

module frame_rate_window_statistics_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [frws_pkg::ENTRY_W-1:0]  req_interval_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [frws_pkg::RATE_W-1:0]   rsp_fps_recent_centi,
   output logic [frws_pkg::RATE_W-1:0]   rsp_fps_min_centi,
   output logic [frws_pkg::RATE_W-1:0]   rsp_fps_avg_centi,
   output logic [frws_pkg::RATE_W-1:0]   rsp_fps_max_centi
);
   import frws_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_FLUSH = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in, wp_next;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               acc_en_ff, acc_en_in;
   logic [CNT_W-1:0]   acc_k_ff, acc_k_in;
   logic [SUM_W-1:0]   recent_ff, recent_in;
   logic [SUM_W-1:0]   all_ff, all_in;
   logic [ENTRY_W-1:0] small_ff, small_in;
   logic [ENTRY_W-1:0] large_ff, large_in;
   res_sel_type        sel_ff, sel_in;
   logic               issue_ff, issue_in;
   logic [RATE_W-1:0]  res_recent_ff, res_recent_in;
   logic [RATE_W-1:0]  res_min_ff, res_min_in;
   logic [RATE_W-1:0]  res_avg_ff, res_avg_in;
   logic [RATE_W-1:0]  res_max_ff, res_max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rsp_recent_ff, rsp_recent_in;
   logic [RATE_W-1:0]  rsp_min_ff, rsp_min_in;
   logic [RATE_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [RATE_W-1:0]  rsp_max_ff, rsp_max_in;

   logic               req_accept;
   logic [ENTRY_W-1:0] entry;
   ring_cmd_type       ring_cmd;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   frws_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_cmd (ring_cmd),
      .rd_entry (entry)
   );

   frws_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign wp_next    = (wp_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   always_comb begin
      ring_cmd.wr_en   = req_accept;
      ring_cmd.wr_addr = wp_next;
      ring_cmd.wr_data = (req_interval_ms == '0) ? ENTRY_W'(1) : req_interval_ms;
      ring_cmd.rd_en   = (state_ff == ST_WALK);
      ring_cmd.rd_addr = rd_addr_ff;
   end

   always_comb begin
      div_req.start = issue_ff;
      case (sel_ff)
         RES_RECENT: begin
            div_req.dividend = DIVIDEND_RECENT;
            div_req.divisor  = recent_ff;
         end
         RES_MIN: begin
            div_req.dividend = DIVIDEND_SINGLE;
            div_req.divisor  = SUM_W'(large_ff);
         end
         RES_AVG: begin
            div_req.dividend = DIVIDEND_AVG;
            div_req.divisor  = all_ff;
         end
         default: begin
            div_req.dividend = DIVIDEND_SINGLE;
            div_req.divisor  = SUM_W'(small_ff);
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rd_addr_in    = rd_addr_ff;
      cnt_in        = cnt_ff;
      acc_en_in     = 1'b0;
      acc_k_in      = acc_k_ff;
      recent_in     = recent_ff;
      all_in        = all_ff;
      small_in      = small_ff;
      large_in      = large_ff;
      sel_in        = sel_ff;
      issue_in      = 1'b0;
      res_recent_in = res_recent_ff;
      res_min_in    = res_min_ff;
      res_avg_in    = res_avg_ff;
      res_max_in    = res_max_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_recent_in = rsp_recent_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_max_in    = rsp_max_ff;

      // read data lands in the cycle after the address; acc_k tags its walk step
      if (acc_en_ff) begin
         if (32'(acc_k_ff) < RECENT_FRAMES) begin
            recent_in = recent_ff + SUM_W'(entry);
         end
         if (32'(acc_k_ff) < HISTORY_DEPTH) begin
            all_in = all_ff + SUM_W'(entry);
            if (entry < small_ff) begin
               small_in = entry;
            end
            if (entry > large_ff) begin
               large_in = entry;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               wp_in      = wp_next;
               rd_addr_in = wp_next;
               cnt_in     = '0;
               recent_in  = '0;
               all_in     = '0;
               small_in   = '1;
               large_in   = '0;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            // newest entry first, backward with wrap
            rd_addr_in = (rd_addr_ff == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : rd_addr_ff - 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            acc_en_in  = 1'b1;
            acc_k_in   = cnt_ff;
            if (cnt_ff == CNT_W'(WALK_LEN - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            sel_in   = RES_RECENT;
            issue_in = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               case (sel_ff)
                  RES_RECENT: begin
                     res_recent_in = div_rsp.quotient;
                     sel_in        = RES_MIN;
                     issue_in      = 1'b1;
                  end
                  RES_MIN: begin
                     res_min_in = div_rsp.quotient;
                     sel_in     = RES_AVG;
                     issue_in   = 1'b1;
                  end
                  RES_AVG: begin
                     res_avg_in = div_rsp.quotient;
                     sel_in     = RES_MAX;
                     issue_in   = 1'b1;
                  end
                  default: begin
                     res_max_in = div_rsp.quotient;
                     state_in   = ST_HOLD;
                  end
               endcase
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_recent_in = res_recent_ff;
               rsp_min_in    = res_min_ff;
               rsp_avg_in    = res_avg_ff;
               rsp_max_in    = res_max_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         acc_en_ff    <= 1'b0;
         sel_ff       <= RES_RECENT;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         acc_en_ff    <= acc_en_in;
         sel_ff       <= sel_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      acc_k_ff      <= acc_k_in;
      recent_ff     <= recent_in;
      all_ff        <= all_in;
      small_ff      <= small_in;
      large_ff      <= large_in;
      res_recent_ff <= res_recent_in;
      res_min_ff    <= res_min_in;
      res_avg_ff    <= res_avg_in;
      res_max_ff    <= res_max_in;
      rsp_recent_ff <= rsp_recent_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_max_ff    <= rsp_max_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fps_recent_centi = rsp_recent_ff;
   assign rsp_fps_min_centi    = rsp_min_ff;
   assign rsp_fps_avg_centi    = rsp_avg_ff;
   assign rsp_fps_max_centi    = rsp_max_ff;

endmodule

`default_nettype wire

// ----- rtl/core/frws_ring.sv -----
// Interval history ring: single-port write, registered read.
// Depends on frws_pkg. Per-entry valid bits make unwritten entries read as 1.
`default_nettype none

module frws_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  frws_pkg::ring_cmd_type         ring_cmd,
   output logic [frws_pkg::ENTRY_W-1:0]   rd_entry
);
   import frws_pkg::*;

   logic [ENTRY_W-1:0]       mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] vld_ff;
   logic [HISTORY_DEPTH-1:0] vld_in;
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic                     rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (ring_cmd.wr_en) begin
         vld_in[ring_cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_cmd.wr_en) begin
         mem[ring_cmd.wr_addr] <= ring_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_cmd.rd_en) begin
         rd_data_ff <= mem[ring_cmd.rd_addr];
         rd_vld_ff  <= vld_ff[ring_cmd.rd_addr];
      end
   end

   // entry never written since reset reads as one
   assign rd_entry = rd_vld_ff ? rd_data_ff : ENTRY_W'(1);

endmodule

`default_nettype wire

// ----- rtl/core/frws_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on frws_pkg. Result is truncated to the rate width.
`default_nettype none

module frws_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  frws_pkg::div_req_type  div_req,
   output frws_pkg::div_rsp_type  div_rsp
);
   import frws_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [SUM_W-1:0]     dvs_ff, dvs_in;
   logic [SUM_W:0]       trial;
   logic [SUM_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top trial bit drops safely
         rem_in = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[RATE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/frws_checker.sv -----
// Port-level checker for the frame rate window statistics core, bound to the top.
// Depends on frws_pkg and frame_rate_window_statistics_core_defines.svh.
`default_nettype none
`include "frame_rate_window_statistics_core_defines.svh"

module frws_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [frws_pkg::RATE_W-1:0]  rsp_fps_recent_centi,
   input logic [frws_pkg::RATE_W-1:0]  rsp_fps_min_centi,
   input logic [frws_pkg::RATE_W-1:0]  rsp_fps_avg_centi,
   input logic [frws_pkg::RATE_W-1:0]  rsp_fps_max_centi
);
   import frws_pkg::*;

   // a request keeps the core busy for the whole walk
   `FRWS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "core took a second request at once")

   // shortest interval gives the highest rate
   `FRWS_ASSERT(a_min_le_max, rsp_valid, rsp_fps_min_centi <= rsp_fps_max_centi, "min rate above max rate")

   // a mean interval lies between the extremes of the ring
   `FRWS_ASSERT(a_avg_in_range, rsp_valid, (rsp_fps_avg_centi >= rsp_fps_min_centi) && (rsp_fps_avg_centi <= rsp_fps_max_centi), "average rate outside min..max")

   `FRWS_ASSERT(a_recent_in_range, rsp_valid, (rsp_fps_recent_centi >= rsp_fps_min_centi) && (rsp_fps_recent_centi <= rsp_fps_max_centi), "recent rate outside min..max")

   `FRWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fps_avg_centi), "stalled result dropped or changed")

endmodule

bind frame_rate_window_statistics_core frws_checker u_frws_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_fps_recent_centi (rsp_fps_recent_centi),
   .rsp_fps_min_centi    (rsp_fps_min_centi),
   .rsp_fps_avg_centi    (rsp_fps_avg_centi),
   .rsp_fps_max_centi    (rsp_fps_max_centi)
);

`default_nettype wire
